>>> src/p1305_pkg.sv
`timescale 1ns / 1ps

package p1305_pkg;

    localparam int NLIMB   = 5;
    localparam int LIMB_W  = 26;
    localparam int ACC_W   = LIMB_W + 1;
    localparam int H_W     = LIMB_W + 2;
    localparam int COEF_W  = LIMB_W + 3;
    localparam int PROD_W  = H_W + COEF_W;
    localparam int DSUM_W  = PROD_W + 3;
    localparam int CARRY_W = DSUM_W - LIMB_W;
    localparam int FOLD_W  = CARRY_W + 4;
    localparam int IDX_W   = 3;
    localparam int WORD_W  = 64;
    localparam int CNT_W   = 5;
    localparam int NBYTES  = 16;
    localparam int MSG_W   = 8 * NBYTES;
    localparam int CFG_IDX_W = 2;
    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 2 * WORD_W;

    localparam logic [IDX_W-1:0] LAST_LIMB = IDX_W'(NLIMB - 1);

    localparam logic [LIMB_W-1:0] R0_MASK = 26'h3ffffff;
    localparam logic [LIMB_W-1:0] R1_MASK = 26'h3ffff03;
    localparam logic [LIMB_W-1:0] R2_MASK = 26'h3ffc0ff;
    localparam logic [LIMB_W-1:0] R3_MASK = 26'h3f03fff;
    localparam logic [LIMB_W-1:0] R4_MASK = 26'h00fffff;
    localparam logic [ACC_W-1:0]  FOLD_MUL = ACC_W'(5);
    localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(NBYTES);

    localparam logic [CFG_IDX_W-1:0] CFG_R_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_R_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_S_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_S_HIGH = 2'd3;

    typedef logic [LIMB_W-1:0] limb_t;
    typedef logic [ACC_W-1:0]  acc_limb_t;
    typedef logic [H_W-1:0]    h_limb_t;
    typedef limb_t     [NLIMB-1:0] rvec_t;
    typedef acc_limb_t [NLIMB-1:0] avec_t;
    typedef h_limb_t   [NLIMB-1:0] hvec_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ABSORB,
        ST_FIN_C1,
        ST_FIN_C2,
        ST_FIN_C3,
        ST_FIN_C4,
        ST_FIN_C0,
        ST_FIN_G0,
        ST_FIN_G1,
        ST_FIN_G2,
        ST_FIN_G3,
        ST_FIN_G4,
        ST_FIN_LO,
        ST_FIN_HI
    } state_t;

    // r split into 26-bit limbs with the clamp applied
    function automatic rvec_t clamp_r(input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi);
        rvec_t rv;
        rv[0] = lo[25:0] & R0_MASK;
        rv[1] = lo[51:26] & R1_MASK;
        rv[2] = {hi[13:0], lo[63:52]} & R2_MASK;
        rv[3] = hi[39:14] & R3_MASK;
        rv[4] = {2'b00, hi[63:40]} & R4_MASK;
        return rv;
    endfunction

endpackage

>>> src/p1305_mult.sv
`timescale 1ns / 1ps

module p1305_mult (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  p1305_pkg::hvec_t   h_in,
    input  logic [63:0]        r_key_low,
    input  logic [63:0]        r_key_high,
    output logic               done,
    output p1305_pkg::avec_t   acc_out
);

    p1305_pkg::rvec_t rv;

    logic                              issue_reg, issue_next;
    logic [p1305_pkg::IDX_W-1:0]       i_reg, i_next;
    logic [p1305_pkg::IDX_W-1:0]       j_reg, j_next;
    logic                              pv_reg, pv_next;
    logic [p1305_pkg::IDX_W-1:0]       pi_reg, pi_next;
    logic [p1305_pkg::IDX_W-1:0]       pj_reg, pj_next;
    logic                              fold_reg, fold_next;
    logic                              done_reg, done_next;

    p1305_pkg::hvec_t                  h_sr_reg, h_sr_next;
    logic [p1305_pkg::PROD_W-1:0]      p_reg, p_next;
    logic [p1305_pkg::DSUM_W-1:0]      d_reg, d_next;
    logic [p1305_pkg::CARRY_W-1:0]     carry_reg, carry_next;
    p1305_pkg::avec_t                  res_reg, res_next;

    logic [p1305_pkg::IDX_W-1:0]       idx;
    p1305_pkg::limb_t                  rsel;
    logic [p1305_pkg::COEF_W-1:0]      coef;
    logic [p1305_pkg::DSUM_W-1:0]      dsum;
    logic [p1305_pkg::FOLD_W-1:0]      h0f;

    assign rv = p1305_pkg::clamp_r(r_key_low, r_key_high);

    // column j of the product uses r[j-i], wrapping limbs pick up the factor 5
    always_comb
    begin
        if (i_reg <= j_reg)
        begin
            idx = j_reg - i_reg;
        end
        else
        begin
            idx = j_reg - i_reg + p1305_pkg::IDX_W'(p1305_pkg::NLIMB);
        end
        case (idx)
            3'd0: rsel = rv[0];
            3'd1: rsel = rv[1];
            3'd2: rsel = rv[2];
            3'd3: rsel = rv[3];
            3'd4: rsel = rv[4];
            default: rsel = rv[0];
        endcase
        if (i_reg > j_reg)
        begin
            coef = (p1305_pkg::COEF_W'(rsel) << 2) + p1305_pkg::COEF_W'(rsel);
        end
        else
        begin
            coef = p1305_pkg::COEF_W'(rsel);
        end
    end

    always_comb
    begin
        issue_next = issue_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        h_sr_next  = h_sr_reg;
        p_next     = p_reg;
        pv_next    = issue_reg;
        pi_next    = i_reg;
        pj_next    = j_reg;
        d_next     = d_reg;
        carry_next = carry_reg;
        res_next   = res_reg;
        fold_next  = 1'b0;
        done_next  = fold_reg;

        dsum = ((pi_reg == '0) ? p1305_pkg::DSUM_W'(carry_reg) : d_reg)
               + p1305_pkg::DSUM_W'(p_reg);
        h0f  = p1305_pkg::FOLD_W'(res_reg[0])
               + (p1305_pkg::FOLD_W'(carry_reg) << 2)
               + p1305_pkg::FOLD_W'(carry_reg);

        if (start)
        begin
            issue_next = 1'b1;
            i_next     = '0;
            j_next     = '0;
            h_sr_next  = h_in;
            carry_next = '0;
        end
        else if (issue_reg)
        begin
            p_next = h_sr_reg[0] * coef;
            // rotate so the next h limb sits at the multiplier input
            for (int k = 0; k < p1305_pkg::NLIMB; k++)
            begin
                h_sr_next[k] = h_sr_reg[(k + 1) % p1305_pkg::NLIMB];
            end
            if (i_reg == p1305_pkg::LAST_LIMB)
            begin
                i_next = '0;
                if (j_reg == p1305_pkg::LAST_LIMB)
                begin
                    issue_next = 1'b0;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            else
            begin
                i_next = i_reg + 1'b1;
            end
        end

        if (pv_reg)
        begin
            if (pi_reg == p1305_pkg::LAST_LIMB)
            begin
                res_next[pj_reg] = {1'b0, dsum[p1305_pkg::LIMB_W-1:0]};
                carry_next       = dsum[p1305_pkg::DSUM_W-1:p1305_pkg::LIMB_W];
                fold_next        = (pj_reg == p1305_pkg::LAST_LIMB);
            end
            else
            begin
                d_next = dsum;
            end
        end

        // top carry wraps to limb 0 times 5
        if (fold_reg)
        begin
            res_next[0] = {1'b0, h0f[p1305_pkg::LIMB_W-1:0]};
            res_next[1] = res_reg[1]
                          + p1305_pkg::ACC_W'(h0f[p1305_pkg::FOLD_W-1:p1305_pkg::LIMB_W]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            pv_reg    <= 1'b0;
            pi_reg    <= '0;
            pj_reg    <= '0;
            fold_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            issue_reg <= issue_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            pv_reg    <= pv_next;
            pi_reg    <= pi_next;
            pj_reg    <= pj_next;
            fold_reg  <= fold_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_sr_reg  <= h_sr_next;
        p_reg     <= p_next;
        d_reg     <= d_next;
        carry_reg <= carry_next;
        res_reg   <= res_next;
    end

    assign done    = done_reg;
    assign acc_out = res_reg;

endmodule

>>> src/poly1305_mac_core.sv
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  message block, byte count, tlast = last
// m_axis    out  m_axis_tvalid / m_axis_tready  16-byte tag
// cfg       in   cfg_valid / cfg_ready          register index and 64-bit key word
//
// a block with a nonzero byte count keeps the core busy from accept to the next accept:
// 25 limb products through the single 28x29 multiplier, then drain, fold and write back
// a last block then adds the final reduction and pad add; an empty last block runs only those
// reset clears the accumulator, the key registers and the output valid flag
// a held tag only stalls the final step of the next last block; input is taken only when idle
`timescale 1ns / 1ps

module poly1305_mac_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [135:0]  s_axis_tdata,   // block_low, block_high, byte_count, zero fill
    input  logic          s_axis_tlast,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [127:0]  m_axis_tdata,   // tag_low, tag_high
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [63:0]   cfg_data
);

    p1305_pkg::state_t              state_reg, state_next;
    p1305_pkg::avec_t               acc_reg, acc_next;
    logic                           last_reg, last_next;
    p1305_pkg::limb_t [3:0]         g_reg, g_next;
    logic                           gc_reg, gc_next;
    logic [63:0]                    tag_lo_reg, tag_lo_next;
    logic                           lo_c_reg, lo_c_next;
    logic                           out_valid_reg, out_valid_next;
    logic [127:0]                   out_data_reg, out_data_next;
    logic [63:0]                    r_low_reg, r_high_reg, s_low_reg, s_high_reg;

    logic                           in_ready;
    logic                           mult_start;
    logic                           mult_done;
    logic                           out_load;
    p1305_pkg::avec_t               mult_acc;
    p1305_pkg::hvec_t               h_in;

    logic [p1305_pkg::CNT_W-1:0]    cnt_sat;
    logic [p1305_pkg::MSG_W-1:0]    msg;
    logic                           hibit;
    logic [63:0]                    pack_lo, pack_hi;
    logic [64:0]                    sum_lo;
    logic [63:0]                    sum_hi;
    logic [p1305_pkg::ACC_W-1:0]    t;

    // message padding, split into limbs and added to the accumulator
    always_comb
    begin
        cnt_sat = (s_axis_tdata[132:128] > p1305_pkg::FULL_COUNT) ?
                  p1305_pkg::FULL_COUNT : s_axis_tdata[132:128];
        hibit   = (cnt_sat == p1305_pkg::FULL_COUNT);
        for (int k = 0; k < p1305_pkg::NBYTES; k++)
        begin
            if (p1305_pkg::CNT_W'(k) < cnt_sat)
            begin
                msg[8*k +: 8] = s_axis_tdata[8*k +: 8];
            end
            else if (p1305_pkg::CNT_W'(k) == cnt_sat)
            begin
                msg[8*k +: 8] = 8'h01;
            end
            else
            begin
                msg[8*k +: 8] = 8'h00;
            end
        end
        h_in[0] = p1305_pkg::H_W'(acc_reg[0]) + p1305_pkg::H_W'(msg[25:0]);
        h_in[1] = p1305_pkg::H_W'(acc_reg[1]) + p1305_pkg::H_W'(msg[51:26]);
        h_in[2] = p1305_pkg::H_W'(acc_reg[2]) + p1305_pkg::H_W'(msg[77:52]);
        h_in[3] = p1305_pkg::H_W'(acc_reg[3]) + p1305_pkg::H_W'(msg[103:78]);
        h_in[4] = p1305_pkg::H_W'(acc_reg[4]) + p1305_pkg::H_W'({hibit, msg[127:104]});
    end

    p1305_mult u_mult (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (mult_start),
        .h_in       (h_in),
        .r_key_low  (r_low_reg),
        .r_key_high (r_high_reg),
        .done       (mult_done),
        .acc_out    (mult_acc)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            p1305_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (cnt_sat != '0)
                    begin
                        state_next = p1305_pkg::ST_ABSORB;
                    end
                    else if (s_axis_tlast)
                    begin
                        state_next = p1305_pkg::ST_FIN_C1;
                    end
                end
            end
            p1305_pkg::ST_ABSORB:
            begin
                if (mult_done)
                begin
                    state_next = last_reg ? p1305_pkg::ST_FIN_C1 : p1305_pkg::ST_IDLE;
                end
            end
            p1305_pkg::ST_FIN_C1: state_next = p1305_pkg::ST_FIN_C2;
            p1305_pkg::ST_FIN_C2: state_next = p1305_pkg::ST_FIN_C3;
            p1305_pkg::ST_FIN_C3: state_next = p1305_pkg::ST_FIN_C4;
            p1305_pkg::ST_FIN_C4: state_next = p1305_pkg::ST_FIN_C0;
            p1305_pkg::ST_FIN_C0: state_next = p1305_pkg::ST_FIN_G0;
            p1305_pkg::ST_FIN_G0: state_next = p1305_pkg::ST_FIN_G1;
            p1305_pkg::ST_FIN_G1: state_next = p1305_pkg::ST_FIN_G2;
            p1305_pkg::ST_FIN_G2: state_next = p1305_pkg::ST_FIN_G3;
            p1305_pkg::ST_FIN_G3: state_next = p1305_pkg::ST_FIN_G4;
            p1305_pkg::ST_FIN_G4: state_next = p1305_pkg::ST_FIN_LO;
            p1305_pkg::ST_FIN_LO: state_next = p1305_pkg::ST_FIN_HI;
            p1305_pkg::ST_FIN_HI:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = p1305_pkg::ST_IDLE;
                end
            end
            default: state_next = p1305_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready   = 1'b0;
        mult_start = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            p1305_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                mult_start = s_axis_tvalid && (cnt_sat != '0);
            end
            p1305_pkg::ST_FIN_HI:
            begin
                out_load = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // accumulator update, final reduction one limb per step, and pad add in two 64-bit halves
    always_comb
    begin
        acc_next      = acc_reg;
        last_next     = last_reg;
        g_next        = g_reg;
        gc_next       = gc_reg;
        tag_lo_next   = tag_lo_reg;
        lo_c_next     = lo_c_reg;
        out_data_next = out_data_reg;
        t             = '0;

        pack_lo = 64'(acc_reg[0]) | (64'(acc_reg[1]) << 26) | (64'(acc_reg[2]) << 52);
        pack_hi = (64'(acc_reg[2]) >> 12) | (64'(acc_reg[3]) << 14) | (64'(acc_reg[4]) << 40);
        sum_lo  = 65'(pack_lo) + 65'(s_low_reg);
        sum_hi  = pack_hi + s_high_reg + 64'(lo_c_reg);

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        case (state_reg)
            p1305_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    last_next = s_axis_tlast;
                end
            end
            p1305_pkg::ST_ABSORB:
            begin
                if (mult_done)
                begin
                    acc_next = mult_acc;
                end
            end
            p1305_pkg::ST_FIN_C1:
            begin
                acc_next[1] = {1'b0, acc_reg[1][25:0]};
                acc_next[2] = acc_reg[2] + p1305_pkg::ACC_W'(acc_reg[1][26]);
            end
            p1305_pkg::ST_FIN_C2:
            begin
                acc_next[2] = {1'b0, acc_reg[2][25:0]};
                acc_next[3] = acc_reg[3] + p1305_pkg::ACC_W'(acc_reg[2][26]);
            end
            p1305_pkg::ST_FIN_C3:
            begin
                acc_next[3] = {1'b0, acc_reg[3][25:0]};
                acc_next[4] = acc_reg[4] + p1305_pkg::ACC_W'(acc_reg[3][26]);
            end
            p1305_pkg::ST_FIN_C4:
            begin
                acc_next[4] = {1'b0, acc_reg[4][25:0]};
                acc_next[0] = acc_reg[0] + (acc_reg[4][26] ? p1305_pkg::FOLD_MUL : '0);
            end
            p1305_pkg::ST_FIN_C0:
            begin
                acc_next[0] = {1'b0, acc_reg[0][25:0]};
                acc_next[1] = acc_reg[1] + p1305_pkg::ACC_W'(acc_reg[0][26]);
            end
            // g = h + 5, carried limb by limb
            p1305_pkg::ST_FIN_G0:
            begin
                t         = acc_reg[0] + p1305_pkg::FOLD_MUL;
                g_next[0] = t[25:0];
                gc_next   = t[26];
            end
            p1305_pkg::ST_FIN_G1:
            begin
                t         = acc_reg[1] + p1305_pkg::ACC_W'(gc_reg);
                g_next[1] = t[25:0];
                gc_next   = t[26];
            end
            p1305_pkg::ST_FIN_G2:
            begin
                t         = acc_reg[2] + p1305_pkg::ACC_W'(gc_reg);
                g_next[2] = t[25:0];
                gc_next   = t[26];
            end
            p1305_pkg::ST_FIN_G3:
            begin
                t         = acc_reg[3] + p1305_pkg::ACC_W'(gc_reg);
                g_next[3] = t[25:0];
                gc_next   = t[26];
            end
            p1305_pkg::ST_FIN_G4:
            begin
                t = acc_reg[4] + p1305_pkg::ACC_W'(gc_reg);
                // reaching 2^130 means h >= p, so take h - p
                if (t[26])
                begin
                    acc_next[0] = {1'b0, g_reg[0]};
                    acc_next[1] = {1'b0, g_reg[1]};
                    acc_next[2] = {1'b0, g_reg[2]};
                    acc_next[3] = {1'b0, g_reg[3]};
                    acc_next[4] = {1'b0, t[25:0]};
                end
            end
            p1305_pkg::ST_FIN_LO:
            begin
                tag_lo_next = sum_lo[63:0];
                lo_c_next   = sum_lo[64];
            end
            p1305_pkg::ST_FIN_HI:
            begin
                if (out_load)
                begin
                    out_data_next  = {sum_hi, tag_lo_reg};
                    out_valid_next = 1'b1;
                    acc_next       = '0;
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= p1305_pkg::ST_IDLE;
            acc_reg       <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            r_low_reg     <= '0;
            r_high_reg    <= '0;
            s_low_reg     <= '0;
            s_high_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    p1305_pkg::CFG_R_LOW:  r_low_reg  <= cfg_data;
                    p1305_pkg::CFG_R_HIGH: r_high_reg <= cfg_data;
                    p1305_pkg::CFG_S_LOW:  s_low_reg  <= cfg_data;
                    p1305_pkg::CFG_S_HIGH: s_high_reg <= cfg_data;
                    default:               r_low_reg  <= r_low_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg        <= g_next;
        gc_reg       <= gc_next;
        tag_lo_reg   <= tag_lo_next;
        lo_c_reg     <= lo_c_next;
        out_data_reg <= out_data_next;
    end

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = 1'b1;

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT     = 1500000;
    localparam int DRAIN_CYCLES    = 64;
    localparam int HOLD_CYCLES     = 600;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 170;

    localparam logic [259:0] PRIME_P   = (260'd1 << 130) - 260'd5;
    localparam logic [259:0] LOW130    = (260'd1 << 130) - 260'd1;
    localparam logic [127:0] CLAMP_MASK = 128'h0ffffffc_0ffffffc_0ffffffc_0fffffff;
    localparam logic [p1305_pkg::WORD_W-1:0] ONES = {p1305_pkg::WORD_W{1'b1}};

    typedef struct packed {
        logic [p1305_pkg::WORD_W-1:0] hi;
        logic [p1305_pkg::WORD_W-1:0] lo;
    } tag_t;

    typedef enum logic {ROW_CFG, ROW_BLK} row_kind_t;

    typedef struct {
        row_kind_t                       kind;
        logic [p1305_pkg::CFG_IDX_W-1:0] idx;
        logic [p1305_pkg::WORD_W-1:0]    lo;
        logic [p1305_pkg::WORD_W-1:0]    hi;
        logic [p1305_pkg::CNT_W-1:0]     cnt;
        logic                            last;
        logic                            has_exp;
        tag_t                            exp;
    } row_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [p1305_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                              s_axis_tlast = 1'b0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [p1305_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [p1305_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [p1305_pkg::WORD_W-1:0]      cfg_data = '0;

    // predictor state: accumulator kept fully reduced mod 2^130-5
    logic [129:0]                 acc_val = '0;
    logic [p1305_pkg::WORD_W-1:0] key_r_lo = '0;
    logic [p1305_pkg::WORD_W-1:0] key_r_hi = '0;
    logic [p1305_pkg::WORD_W-1:0] key_s_lo = '0;
    logic [p1305_pkg::WORD_W-1:0] key_s_hi = '0;

    tag_t tag_q[$];
    row_t rows[$];
    int   mismatches = 0;
    int   cycles = 0;
    int   src_idle_pct = 0;
    int   sink_stall_pct = 0;
    logic hold_req = 1'b0;
    logic hold_ack = 1'b0;
    int   hold_left = 0;

    poly1305_mac_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [259:0] mul_mod_p(input logic [259:0] a, input logic [259:0] b);
        logic [259:0] w;
        w = a * b;
        while ((w >> 130) != 0)
            w = (w & LOW130) + 260'd5 * (w >> 130);
        if (w >= PRIME_P)
            w = w - PRIME_P;
        return w;
    endfunction

    // absorbs a nonempty block into the accumulator, gives the tag on last
    task automatic poly_step(input logic [p1305_pkg::WORD_W-1:0] lo,
                             input logic [p1305_pkg::WORD_W-1:0] hi,
                             input logic [p1305_pkg::CNT_W-1:0] cnt, input logic last,
                             output logic got, output tag_t t);
        int           n;
        logic [127:0] data;
        logic [127:0] sum;
        logic [259:0] m;
        logic [259:0] a;
        logic [259:0] r;
        logic [259:0] w;
        n = (cnt > p1305_pkg::CNT_W'(p1305_pkg::NBYTES)) ? p1305_pkg::NBYTES : int'(cnt);
        got = 1'b0;
        t = '0;
        m = '0;
        data = {hi, lo};
        if (n == p1305_pkg::NBYTES)
            m = {132'd1, data};
        else if (n > 0)
        begin
            data = (data & ((128'd1 << (8 * n)) - 128'd1)) | (128'd1 << (8 * n));
            m = 260'(data);
        end
        if (n > 0)
        begin
            a = 260'(acc_val);
            r = 260'({key_r_hi, key_r_lo} & CLAMP_MASK);
            w = mul_mod_p(a + m, r);
            acc_val = w[129:0];
        end
        if (last)
        begin
            sum = acc_val[127:0] + {key_s_hi, key_s_lo};
            t.lo = sum[63:0];
            t.hi = sum[127:64];
            got = 1'b1;
            acc_val = '0;
        end
    endtask

    task automatic send_block(input logic [p1305_pkg::WORD_W-1:0] lo,
                              input logic [p1305_pkg::WORD_W-1:0] hi,
                              input logic [p1305_pkg::CNT_W-1:0] cnt, input logic last,
                              input logic has_exp, input tag_t exp);
        logic got;
        tag_t t;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, cnt, hi, lo};
        s_axis_tlast  <= last;
        do @(negedge clk); while (!s_axis_tready);
        @(posedge clk);
        poly_step(lo, hi, cnt, last, got, t);
        if (got)
            tag_q.push_back(has_exp ? exp : t);
    endtask

    task automatic write_reg(input logic [p1305_pkg::CFG_IDX_W-1:0] idx,
                             input logic [p1305_pkg::WORD_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            p1305_pkg::CFG_R_LOW:  key_r_lo = d;
            p1305_pkg::CFG_R_HIGH: key_r_hi = d;
            p1305_pkg::CFG_S_LOW:  key_s_lo = d;
            p1305_pkg::CFG_S_HIGH: key_s_hi = d;
            default:    ;
        endcase
        @(posedge clk);
    endtask

    // wait for every tag, then let an in-flight non-last block finish
    task automatic drain_tags();
        s_axis_tvalid <= 1'b0;
        while (tag_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic void add_cfg(input logic [p1305_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [p1305_pkg::WORD_W-1:0] d);
        row_t row;
        row = '{kind: ROW_CFG, idx: idx, lo: d, hi: '0, cnt: '0, last: 1'b0,
                has_exp: 1'b0, exp: '0};
        rows.push_back(row);
    endfunction

    function automatic void add_blk(input logic [p1305_pkg::WORD_W-1:0] lo,
                                    input logic [p1305_pkg::WORD_W-1:0] hi,
                                    input logic [p1305_pkg::CNT_W-1:0] cnt, input logic last,
                                    input logic has_exp, input tag_t exp);
        row_t row;
        row = '{kind: ROW_BLK, idx: '0, lo: lo, hi: hi, cnt: cnt, last: last,
                has_exp: has_exp, exp: exp};
        rows.push_back(row);
    endfunction

    // tag sink: random stalls plus a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
        end
        else if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (hold_req != hold_ack)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_CYCLES;
            hold_ack      <= hold_req;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // outputs are stable at the falling edge; a request seen here is taken at the next rise
    always @(negedge clk)
    begin : tag_check
        tag_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (tag_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected tag %h", m_axis_tdata);
            end
            else
            begin
                want = tag_q.pop_front();
                if (m_axis_tdata[63:0] !== want.lo || m_axis_tdata[127:64] !== want.hi)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tag mismatch: expected lo %h hi %h, got lo %h hi %h",
                                 want.lo, want.hi, m_axis_tdata[63:0], m_axis_tdata[127:64]);
                end
            end
        end
    end

    initial
    begin : stimulus
        int                           ph;
        int                           k;
        int                           blocks_left;
        logic [p1305_pkg::WORD_W-1:0] lo;
        logic [p1305_pkg::WORD_W-1:0] hi;
        logic [p1305_pkg::CNT_W-1:0]  cnt;
        logic                         last;
        tag_t                         none;
        row_t                         row;

        none = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // zero key after reset: tag is zero
        add_blk(ONES, ONES, 5'd16, 1'b1, 1'b1, '{hi: '0, lo: '0});
        add_cfg(p1305_pkg::CFG_S_LOW, ONES);
        add_cfg(p1305_pkg::CFG_S_HIGH, ONES);
        // empty tail on a fresh accumulator gives the pad
        add_blk(ONES, ONES, 5'd0, 1'b1, 1'b1, '{hi: ONES, lo: ONES});
        // r = 1: two blocks summing to exactly the prime reduce to zero
        add_cfg(p1305_pkg::CFG_R_LOW, 64'd1);
        add_blk(ONES, ONES, 5'd16, 1'b0, 1'b0, none);
        add_blk(64'hffff_ffff_ffff_fffc, ONES, 5'd16, 1'b1, 1'b1, '{hi: ONES, lo: ONES});
        // one below the prime stays unreduced
        add_blk(ONES, ONES, 5'd16, 1'b0, 1'b0, none);
        add_blk(64'hffff_ffff_ffff_fffb, ONES, 5'd16, 1'b1, 1'b0, none);
        add_cfg(p1305_pkg::CFG_R_LOW, ONES);
        add_cfg(p1305_pkg::CFG_R_HIGH, ONES);
        add_blk('0, '0, 5'd16, 1'b0, 1'b0, none);
        add_blk(ONES, ONES, 5'd15, 1'b1, 1'b0, none);
        add_blk(ONES, ONES, 5'd1, 1'b1, 1'b0, none);
        // short block that is not last, then the 8 and 9 byte boundaries
        add_blk(ONES, ONES, 5'd7, 1'b0, 1'b0, none);
        add_blk(ONES, ONES, 5'd8, 1'b1, 1'b0, none);
        add_blk(ONES, ONES, 5'd9, 1'b1, 1'b0, none);
        // empty non-last block is ignored
        add_blk(ONES, ONES, 5'd0, 1'b0, 1'b0, none);
        // counts above sixteen saturate
        add_blk(64'h8000_0000_0000_0001, 64'h7fff_ffff_ffff_fffe, 5'd17, 1'b1, 1'b0, none);
        add_blk(64'h5a5a_a5a5_0f0f_f0f0, 64'hc3c3_3c3c_9696_6969, 5'd31, 1'b0, 1'b0, none);
        // key change in the middle of a message
        add_cfg(p1305_pkg::CFG_S_LOW, 64'h0123_4567_89ab_cdef);
        add_cfg(p1305_pkg::CFG_R_HIGH, 64'h0fed_cba9_8765_4321);
        add_blk(64'h1122_3344_5566_7788, 64'h99aa_bbcc_ddee_ff00, 5'd16, 1'b1, 1'b0, none);
        add_blk(ONES, ONES, 5'd12, 1'b1, 1'b0, none);
        add_blk('0, '0, 5'd0, 1'b1, 1'b1, '{hi: ONES, lo: 64'h0123_4567_89ab_cdef});

        foreach (rows[i])
        begin
            row = rows[i];
            if (row.kind == ROW_CFG)
            begin
                drain_tags();
                write_reg(row.idx, row.lo);
            end
            else
                send_block(row.lo, row.hi, row.cnt, row.last, row.has_exp, row.exp);
        end

        blocks_left = 0;
        for (ph = 0; ph < PHASES; ph++)
        begin
            drain_tags();
            case (ph)
                0:
                begin
                    write_reg(p1305_pkg::CFG_R_LOW, ONES);
                    write_reg(p1305_pkg::CFG_R_HIGH, ONES);
                    write_reg(p1305_pkg::CFG_S_LOW, '0);
                    write_reg(p1305_pkg::CFG_S_HIGH, '0);
                end
                1:
                begin
                    write_reg(p1305_pkg::CFG_R_LOW, '0);
                    write_reg(p1305_pkg::CFG_R_HIGH, '0);
                    write_reg(p1305_pkg::CFG_S_LOW, ONES);
                    write_reg(p1305_pkg::CFG_S_HIGH, ONES);
                end
                default:
                begin
                    write_reg(p1305_pkg::CFG_R_LOW, {$urandom, $urandom});
                    write_reg(p1305_pkg::CFG_R_HIGH, {$urandom, $urandom});
                    write_reg(p1305_pkg::CFG_S_LOW, {$urandom, $urandom});
                    write_reg(p1305_pkg::CFG_S_HIGH, {$urandom, $urandom});
                end
            endcase
            case (ph % 4)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 78; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 78; end
                default: begin src_idle_pct = 11; sink_stall_pct = 11; end
            endcase
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // long sink hold-off while blocks keep coming
                if (ph == 4 && k == 30)
                    hold_req <= ~hold_req;
                if (ph == 5 && k == 60)
                    drain_tags();
                lo = {$urandom, $urandom};
                hi = {$urandom, $urandom};
                if ($urandom_range(99) < 15)
                begin
                    cnt  = p1305_pkg::CNT_W'($urandom_range(31));
                    last = 1'($urandom_range(1));
                end
                else if (blocks_left > 0)
                begin
                    cnt  = p1305_pkg::CNT_W'(p1305_pkg::NBYTES);
                    last = 1'b0;
                    blocks_left--;
                end
                else
                begin
                    cnt  = p1305_pkg::CNT_W'($urandom_range(p1305_pkg::NBYTES));
                    last = 1'b1;
                    blocks_left = int'($urandom_range(6));
                end
                send_block(lo, hi, cnt, last, 1'b0, none);
            end
        end

        drain_tags();
        if (mismatches == 0 && tag_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
src/p1305_pkg.sv
src/p1305_mult.sv
src/poly1305_mac_core.sv
sim/tb.sv
